FILE: hdl/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, widths and codes of the transformed path chamfer distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int COORD_WIDTH = 16;

    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int FRAC       = 14;
    localparam int RND_HALF   = 1 << (FRAC - 1);
    localparam int SC_W       = COORD_WIDTH + 3;      // scaled coordinate
    localparam int PT_W       = COORD_WIDTH + 6;      // transformed coordinate
    localparam int DIFF_W     = PT_W + 1;
    localparam int MUL_W      = DIFF_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DSQ_W      = 2 * DIFF_W + 1;
    localparam int SQ_SHIFT   = 10;
    localparam int RAD_W      = DSQ_W + SQ_SHIFT + 1; // even
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SUM_W      = ROOT_W + CNT_W;
    localparam int SQ_CNT_W   = $clog2(ROOT_W + 1);
    localparam int DV_CNT_W   = $clog2(SUM_W + 1);
    localparam int SCORE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int OFS_W      = 13;
    localparam int SPT_W      = 2 * COORD_WIDTH;
    localparam int MPT_W      = 2 * PT_W;

    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFS_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFS_Y = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ONE_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_LOAD_SRC = 2'd1,
        ACT_LOAD_TGT = 2'd2,
        ACT_COMPUTE  = 2'd3
    } act_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_MX,
        ST_T_MY,
        ST_T_C1,
        ST_T_C2,
        ST_T_C3,
        ST_T_C4,
        ST_T_C5,
        ST_N_RDA,
        ST_N_LDA,
        ST_N_RDB,
        ST_N_DX,
        ST_N_DY,
        ST_N_CMP,
        ST_N_SQ,
        ST_N_SQW,
        ST_N_DV,
        ST_N_DVW,
        ST_RESULT
    } state_t;

    // round half up, then drop FRAC fraction bits
    function automatic logic signed [PROD_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] h;
        h = PROD_W'(RND_HALF);
        return (v + h) >>> FRAC;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tcd_ram.sv
// ----------------------------------------------------------------------------
// tcd_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/tcd_sqrt.sv
// ----------------------------------------------------------------------------
// tcd_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [tcd_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic      [tcd_pkg::ROOT_W-1:0] root
);
    import tcd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W+2:0]   rem_t, trial, rem_d;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_t     = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_d     = rem_t - trial;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = SQ_CNT_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            // remainder stays at most twice the root, so ROOT_W+1 bits
            if (rem_t >= trial) begin
                rem_next  = rem_d[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_t[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SQ_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: hdl/tcd_div.sv
// ----------------------------------------------------------------------------
// tcd_div
// Restoring divider of a distance sum by a point count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [tcd_pkg::SUM_W-1:0] dividend,
    input  wire logic [tcd_pkg::CNT_W-1:0] divisor,
    output logic                           done,
    output logic      [tcd_pkg::SUM_W-1:0] quotient
);
    import tcd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W:0]      trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DV_CNT_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits CNT_W bits
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/transformed_path_chamfer_distance.sv
// ----------------------------------------------------------------------------
// transformed_path_chamfer_distance
// Symmetric chamfer distance between a scaled, rotated and translated source
// path and a target path, on one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                             | transaction
//  --------+-----------+-----------------------------------+----------------------
//  s_      | in        | s_action, s_coord_x, s_coord_y    | clear, load or compute
//  m_      | out       | m_score, m_status                 | one per compute
//  cfg_    | in        | cfg_wr_en, cfg_addr, cfg_wdata    | register write
//
//  Clear and load leave the sequencer in idle; back to back loads run at one per cycle.
//  Compute moves the Ns source points on the shared multiplier, then squares the
//  axis distances of every pair of the Ns source and Nt target points on it, and
//  takes one square root per point and one division per path average.
//  A compute with an empty path goes straight to the result state.
//  Reset is synchronous, active low; s_ready is low while a compute runs and
//  while its result waits for the output register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module transformed_path_chamfer_distance (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [1:0]                            s_action,
    input  wire logic signed [tcd_pkg::COORD_WIDTH-1:0] s_coord_x,
    input  wire logic signed [tcd_pkg::COORD_WIDTH-1:0] s_coord_y,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [tcd_pkg::SCORE_W-1:0]           m_score,
    output logic      [tcd_pkg::STATUS_W-1:0]          m_status,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tcd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [tcd_pkg::CFG_W-1:0]             cfg_wdata
);
    import tcd_pkg::*;

    // configuration
    logic        [CFG_W-1:0] scale_reg;
    logic signed [CFG_W-1:0] cos_reg, sin_reg;
    logic signed [OFS_W-1:0] offs_x_reg, offs_y_reg;

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] src_cnt_reg, src_cnt_next;
    logic [CNT_W-1:0] tgt_cnt_reg, tgt_cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             pass_reg, pass_next;
    logic             m_valid_reg, m_valid_next;

    // datapath
    logic signed [COORD_WIDTH-1:0] py_reg, py_next;
    logic signed [SC_W-1:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next, acc_reg, acc_next;
    logic signed [PT_W-1:0]        rx_reg, rx_next, ry;
    logic signed [PT_W-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic        [DIFF_W-1:0]      dy_reg, dy_next;
    logic        [DSQ_W-1:0]       sq_reg, sq_next, best_reg, best_next, dsq;
    logic        [SUM_W-1:0]       sum_reg, sum_next;
    logic        [SCORE_W-1:0]     score_reg, score_next, m_score_reg, m_score_next;
    logic        [STATUS_W-1:0]    status_reg, status_next, m_status_reg, m_status_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] rnd;

    // memories
    logic             src_we, tgt_we, mv_we;
    logic [SPT_W-1:0] pt_wdata, src_rdata, tgt_rdata;
    logic [MPT_W-1:0] mv_wdata, mv_rdata;
    logic [IDX_W-1:0] tgt_raddr, mv_raddr;

    // point selection and distance
    logic signed [PT_W-1:0]   tx, ty, mx, my, bx, by;
    logic signed [DIFF_W-1:0] dxs, dys;
    logic        [DIFF_W-1:0] dxm, dym;
    logic        [CNT_W-1:0]  na, nb;

    // shared units
    logic              sq_start, sq_done, dv_start, dv_done;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  quotient;

    act_t act;
    assign act = act_t'(s_action);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_score  = m_score_reg;
    assign m_status = m_status_reg;

    assign pt_wdata  = {s_coord_x, s_coord_y};
    assign tgt_raddr = pass_reg ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign mv_raddr  = pass_reg ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign na        = pass_reg ? tgt_cnt_reg : src_cnt_reg;
    assign nb        = pass_reg ? src_cnt_reg : tgt_cnt_reg;

    assign tx = PT_W'($signed(tgt_rdata[SPT_W-1:COORD_WIDTH]));
    assign ty = PT_W'($signed(tgt_rdata[COORD_WIDTH-1:0]));
    assign mx = $signed(mv_rdata[MPT_W-1:PT_W]);
    assign my = $signed(mv_rdata[PT_W-1:0]);
    assign bx = pass_reg ? mx : tx;
    assign by = pass_reg ? my : ty;

    assign dxs = DIFF_W'(ax_reg) - DIFF_W'(bx);
    assign dys = DIFF_W'(ay_reg) - DIFF_W'(by);
    assign dxm = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    assign dym = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
    assign dsq = sq_reg + prod_reg[DSQ_W-1:0];

    assign rnd = (state_reg == ST_T_C3) ? rnd_frac(acc_reg - prod_reg)
               : (state_reg == ST_T_C5) ? rnd_frac(acc_reg + prod_reg)
               :                          rnd_frac(prod_reg);
    assign ry  = rnd[PT_W-1:0] + PT_W'(offs_y_reg);

    assign mv_wdata = {rx_reg, ry};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= CFG_W'(16384);
            cos_reg    <= CFG_W'(16384);
            sin_reg    <= '0;
            offs_x_reg <= '0;
            offs_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SCALE:  scale_reg  <= cfg_wdata;
                REG_COS:    cos_reg    <= $signed(cfg_wdata);
                REG_SIN:    sin_reg    <= $signed(cfg_wdata);
                REG_OFFS_X: offs_x_reg <= $signed(cfg_wdata[OFS_W-1:0]);
                REG_OFFS_Y: offs_y_reg <= $signed(cfg_wdata[OFS_W-1:0]);
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T_MX: begin
                mul_a = MUL_W'($signed(src_rdata[SPT_W-1:COORD_WIDTH]));
                mul_b = $signed({{(MUL_W-CFG_W){1'b0}}, scale_reg});
            end
            ST_T_MY: begin
                mul_a = MUL_W'(py_reg);
                mul_b = $signed({{(MUL_W-CFG_W){1'b0}}, scale_reg});
            end
            ST_T_C1: begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(cos_reg);
            end
            ST_T_C2: begin
                mul_a = MUL_W'(sy_reg);
                mul_b = MUL_W'(sin_reg);
            end
            ST_T_C3: begin
                mul_a = MUL_W'(sy_reg);
                mul_b = MUL_W'(cos_reg);
            end
            ST_T_C4: begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(sin_reg);
            end
            ST_N_DX: begin
                mul_a = $signed({1'b0, dxm});
                mul_b = $signed({1'b0, dxm});
            end
            ST_N_DY: begin
                mul_a = $signed({1'b0, dy_reg});
                mul_b = $signed({1'b0, dy_reg});
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        src_cnt_next  = src_cnt_reg;
        tgt_cnt_next  = tgt_cnt_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pass_next     = pass_reg;
        m_valid_next  = m_valid_reg;
        py_next       = py_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        prod_next     = mul_a * mul_b;
        acc_next      = acc_reg;
        rx_next       = rx_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        dy_next       = dy_reg;
        sq_next       = sq_reg;
        best_next     = best_reg;
        sum_next      = sum_reg;
        score_next    = score_reg;
        status_next   = status_reg;
        m_score_next  = m_score_reg;
        m_status_next = m_status_reg;
        src_we        = 1'b0;
        tgt_we        = 1'b0;
        mv_we         = 1'b0;
        sq_start      = 1'b0;
        dv_start      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (act)
                        ACT_CLEAR: begin
                            src_cnt_next = '0;
                            tgt_cnt_next = '0;
                            ovf_next     = 1'b0;
                        end
                        ACT_LOAD_SRC: begin
                            if (src_cnt_reg < CNT_W'(MAX_POINTS)) begin
                                src_we       = 1'b1;
                                src_cnt_next = src_cnt_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_LOAD_TGT: begin
                            if (tgt_cnt_reg < CNT_W'(MAX_POINTS)) begin
                                tgt_we       = 1'b1;
                                tgt_cnt_next = tgt_cnt_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_COMPUTE: begin
                            score_next  = '0;
                            status_next = ovf_reg ? STATUS_DROPPED : STATUS_OK;
                            i_next      = '0;
                            pass_next   = 1'b0;
                            if ((src_cnt_reg == '0) != (tgt_cnt_reg == '0)) begin
                                score_next  = '1;
                                status_next = STATUS_ONE_EMPTY;
                                state_next  = ST_RESULT;
                            end else if (src_cnt_reg == '0) begin
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_T_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_T_RD: state_next = ST_T_MX;
            ST_T_MX: begin
                py_next    = $signed(src_rdata[COORD_WIDTH-1:0]);
                state_next = ST_T_MY;
            end
            ST_T_MY: begin
                sx_next    = rnd[SC_W-1:0];
                state_next = ST_T_C1;
            end
            ST_T_C1: begin
                sy_next    = rnd[SC_W-1:0];
                state_next = ST_T_C2;
            end
            ST_T_C2: begin
                acc_next   = prod_reg;
                state_next = ST_T_C3;
            end
            ST_T_C3: begin
                rx_next    = rnd[PT_W-1:0] + PT_W'(offs_x_reg);
                state_next = ST_T_C4;
            end
            ST_T_C4: begin
                acc_next   = prod_reg;
                state_next = ST_T_C5;
            end
            ST_T_C5: begin
                mv_we  = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == src_cnt_reg) begin
                    i_next     = '0;
                    sum_next   = '0;
                    state_next = ST_N_RDA;
                end else begin
                    state_next = ST_T_RD;
                end
            end
            ST_N_RDA: state_next = ST_N_LDA;
            ST_N_LDA: begin
                ax_next    = pass_reg ? tx : mx;
                ay_next    = pass_reg ? ty : my;
                best_next  = '1;
                j_next     = '0;
                state_next = ST_N_RDB;
            end
            ST_N_RDB: state_next = ST_N_DX;
            ST_N_DX: begin
                dy_next    = dym;
                state_next = ST_N_DY;
            end
            ST_N_DY: begin
                sq_next    = prod_reg[DSQ_W-1:0];
                state_next = ST_N_CMP;
            end
            ST_N_CMP: begin
                if (dsq < best_reg) begin
                    best_next = dsq;
                end
                j_next     = j_reg + 1'b1;
                state_next = (j_reg + 1'b1 == nb) ? ST_N_SQ : ST_N_RDB;
            end
            ST_N_SQ: begin
                sq_start   = 1'b1;
                state_next = ST_N_SQW;
            end
            ST_N_SQW: begin
                if (sq_done) begin
                    sum_next   = sum_reg + SUM_W'(root);
                    i_next     = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == na) ? ST_N_DV : ST_N_RDA;
                end
            end
            ST_N_DV: begin
                dv_start   = 1'b1;
                state_next = ST_N_DVW;
            end
            ST_N_DVW: begin
                if (dv_done) begin
                    score_next = score_reg + SCORE_W'(quotient[ROOT_W-1:0]);
                    if (!pass_reg) begin
                        pass_next  = 1'b1;
                        i_next     = '0;
                        sum_next   = '0;
                        state_next = ST_N_RDA;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg) begin
                    m_valid_next  = 1'b1;
                    m_score_next  = score_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            src_cnt_reg <= '0;
            tgt_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_cnt_reg <= src_cnt_next;
            tgt_cnt_reg <= tgt_cnt_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        py_reg       <= py_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rx_reg       <= rx_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        dy_reg       <= dy_next;
        sq_reg       <= sq_next;
        best_reg     <= best_next;
        sum_reg      <= sum_next;
        score_reg    <= score_next;
        status_reg   <= status_next;
        m_score_reg  <= m_score_next;
        m_status_reg <= m_status_next;
    end

    tcd_ram #(.WIDTH(SPT_W), .DEPTH(MAX_POINTS)) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (src_cnt_reg[IDX_W-1:0]),
        .wdata (pt_wdata),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (src_rdata)
    );

    tcd_ram #(.WIDTH(SPT_W), .DEPTH(MAX_POINTS)) u_tgt_ram (
        .aclk  (aclk),
        .we    (tgt_we),
        .waddr (tgt_cnt_reg[IDX_W-1:0]),
        .wdata (pt_wdata),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    tcd_ram #(.WIDTH(MPT_W), .DEPTH(MAX_POINTS)) u_mv_ram (
        .aclk  (aclk),
        .we    (mv_we),
        .waddr (i_reg[IDX_W-1:0]),
        .wdata (mv_wdata),
        .raddr (mv_raddr),
        .rdata (mv_rdata)
    );

    tcd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({1'b0, best_reg, {SQ_SHIFT{1'b0}}}),
        .done     (sq_done),
        .root     (root)
    );

    tcd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (sum_reg),
        .divisor  (na),
        .done     (dv_done),
        .quotient (quotient)
    );

endmodule

`default_nettype wire

FILE: hdl/tcd_checker.sv
// ----------------------------------------------------------------------------
// tcd_checker
// Port level checks of the chamfer distance block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic [1:0]                       s_action,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [tcd_pkg::SCORE_W-1:0]      m_score,
    input wire logic [tcd_pkg::STATUS_W-1:0]     m_status
);
    import tcd_pkg::*;

    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score) && $stable(m_status))
        else $error("result changed while stalled");

    // one empty path always reports a saturated score
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_ONE_EMPTY |-> m_score == '1)
        else $error("one-empty status without saturated score");

    // compute transaction makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == ACT_COMPUTE |=> !s_ready)
        else $error("ready right after compute transaction");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind transformed_path_chamfer_distance tcd_checker u_tcd_checker (.*);

`default_nettype wire

FILE: bench/tb_transformed_path_chamfer_distance.sv
// ----------------------------------------------------------------------------
// tb_transformed_path_chamfer_distance
// Self-checking bench: directed and random clear/load/compute traffic, with
// register sets changed between phases, random idle on both channels and a
// scoreboard that recomputes every chamfer score in integer arithmetic.
// ----------------------------------------------------------------------------

class chamfer_scoreboard;
    longint src_x[tcd_pkg::MAX_POINTS], src_y[tcd_pkg::MAX_POINTS];
    longint tgt_x[tcd_pkg::MAX_POINTS], tgt_y[tcd_pkg::MAX_POINTS];
    longint mv_x[tcd_pkg::MAX_POINTS], mv_y[tcd_pkg::MAX_POINTS];
    int unsigned n_src, n_tgt;
    bit dropped;
    longint scale, cosv, sinv, ofs_x, ofs_y;
    logic [31:0] exp_score[$];
    logic [1:0] exp_status[$];
    int errors;

    function new();
        n_src = 0; n_tgt = 0; dropped = 0; errors = 0;
        scale = 16384; cosv = 16384; sinv = 0; ofs_x = 0; ofs_y = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            tcd_pkg::REG_SCALE:  scale = val;
            tcd_pkg::REG_COS:    cosv = longint'($signed(val));
            tcd_pkg::REG_SIN:    sinv = longint'($signed(val));
            tcd_pkg::REG_OFFS_X: ofs_x = longint'($signed(val[12:0]));
            tcd_pkg::REG_OFFS_Y: ofs_y = longint'($signed(val[12:0]));
            default: ;
        endcase
    endfunction

    function longint rnd14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits = bits >> 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function longint unsigned axis_mag(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        if (d > 67108863) d = 67108863;
        return d;
    endfunction

    // sum of nearest distances: from moved source to target, or the reverse
    function longint unsigned nearest_sum(bit from_src);
        longint unsigned total, best, dx, dy, dsq;
        int unsigned na, nb;
        na = from_src ? n_src : n_tgt;
        nb = from_src ? n_tgt : n_src;
        total = 0;
        for (int i = 0; i < na; i++) begin
            best = '1;
            for (int j = 0; j < nb; j++) begin
                if (from_src) begin
                    dx = axis_mag(mv_x[i], tgt_x[j]);
                    dy = axis_mag(mv_y[i], tgt_y[j]);
                end else begin
                    dx = axis_mag(tgt_x[i], mv_x[j]);
                    dy = axis_mag(tgt_y[i], mv_y[j]);
                end
                dsq = dx * dx + dy * dy;
                if (dsq < best) best = dsq;
            end
            total += int_sqrt(best << 10);
        end
        return total;
    endfunction

    function void add_expected(logic [31:0] score, logic [1:0] status);
        exp_score.insert(exp_score.size(), score);
        exp_status.insert(exp_status.size(), status);
    endfunction

    function void note_input(tcd_pkg::act_t act, logic [15:0] x, logic [15:0] y);
        longint unsigned score;
        longint sx, sy;
        case (act)
            tcd_pkg::ACT_CLEAR: begin
                n_src = 0; n_tgt = 0; dropped = 0;
            end
            tcd_pkg::ACT_LOAD_SRC: begin
                if (n_src < tcd_pkg::MAX_POINTS) begin
                    src_x[n_src] = longint'($signed(x));
                    src_y[n_src] = longint'($signed(y));
                    n_src++;
                end else dropped = 1;
            end
            tcd_pkg::ACT_LOAD_TGT: begin
                if (n_tgt < tcd_pkg::MAX_POINTS) begin
                    tgt_x[n_tgt] = longint'($signed(x));
                    tgt_y[n_tgt] = longint'($signed(y));
                    n_tgt++;
                end else dropped = 1;
            end
            default: begin
                if ((n_src == 0) != (n_tgt == 0)) begin
                    add_expected(32'hFFFF_FFFF, tcd_pkg::STATUS_ONE_EMPTY);
                end else begin
                    score = 0;
                    if (n_src != 0) begin
                        for (int i = 0; i < n_src; i++) begin
                            sx = rnd14(src_x[i] * scale);
                            sy = rnd14(src_y[i] * scale);
                            mv_x[i] = rnd14(sx * cosv - sy * sinv) + ofs_x;
                            mv_y[i] = rnd14(sy * cosv + sx * sinv) + ofs_y;
                        end
                        score = nearest_sum(1) / n_src + nearest_sum(0) / n_tgt;
                        if (score > 64'hFFFF_FFFF) score = 64'hFFFF_FFFF;
                    end
                    add_expected(score[31:0], dropped ? tcd_pkg::STATUS_DROPPED
                                                      : tcd_pkg::STATUS_OK);
                end
            end
        endcase
    endfunction

    function void check_result(logic [31:0] score, logic [1:0] status);
        if (exp_score.size() == 0) begin
            $display("%0t: unexpected result score=%h status=%0d", $realtime, score, status);
            errors++;
            return;
        end
        if (score !== exp_score[0]) begin
            $display("%0t: score expected %h actual %h", $realtime, exp_score[0], score);
            errors++;
        end
        if (status !== exp_status[0]) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_status[0], status);
            errors++;
        end
        void'(exp_score.pop_front());
        void'(exp_status.pop_front());
    endfunction

    function int pending();
        return exp_score.size();
    endfunction
endclass

module tb_transformed_path_chamfer_distance;
    timeunit 1ns;
    timeprecision 1ps;
    import tcd_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_action = ACT_CLEAR;
    logic signed [COORD_WIDTH-1:0] s_coord_x = '0;
    logic signed [COORD_WIDTH-1:0] s_coord_y = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [SCORE_W-1:0] m_score;
    logic [STATUS_W-1:0] m_status;
    logic cfg_wr_en = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_SCALE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    chamfer_scoreboard sb = new();
    int hold_left = 0;
    bit src_busy = 0;      // sender burst: no gaps
    int idle_cycles = 0;
    int sent = 0;

    transformed_path_chamfer_distance dut (.*);

    always #6 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom);
        if (r < 8) return 16'($signed($urandom_range(0, 8192)) - 4096);
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_item(act_t act, logic [15:0] x, logic [15:0] y);
        int g;
        g = src_busy ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_coord_x <= x;
        s_coord_y <= y;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(act, x, y);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_regs(logic [15:0] sc, logic [15:0] c, logic [15:0] s,
                              logic [15:0] ox, logic [15:0] oy);
        logic [15:0] vals[5];
        vals = '{sc, c, s, ox, oy};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= CFG_ADDR_W'(i);
            cfg_wdata <= vals[i];
            sb.set_reg(CFG_ADDR_W'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_regs();
        logic [15:0] v[5];
        bit ext;
        ext = ($urandom_range(0, 3) == 0);
        v[0] = ext ? ($urandom_range(0, 1) ? 16'd32768 : 16'd0) : 16'($urandom_range(0, 32768));
        v[1] = ext ? ($urandom_range(0, 1) ? 16'd16384 : -16'sd16384)
                   : 16'($signed($urandom_range(0, 32768)) - 16384);
        v[2] = ext ? ($urandom_range(0, 1) ? 16'd16384 : -16'sd16384)
                   : 16'($signed($urandom_range(0, 32768)) - 16384);
        v[3] = ext ? ($urandom_range(0, 1) ? 16'd2048 : -16'sd2048)
                   : 16'($signed($urandom_range(0, 4096)) - 2048);
        v[4] = ext ? ($urandom_range(0, 1) ? 16'd2048 : -16'sd2048)
                   : 16'($signed($urandom_range(0, 4096)) - 2048);
        write_regs(v[0], v[1], v[2], v[3], v[4]);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) begin
                    @(posedge aclk);
                    if (hold_left > 0) break;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_score, m_status);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int ns, nt, ls, lt, seqs;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty paths, one path empty, coordinate extremes
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_LOAD_SRC, 16'h8000, 16'h8000);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_LOAD_SRC, 16'h7FFF, 16'h7FFF);
        send_item(ACT_LOAD_TGT, 16'h0000, 16'h0000);
        send_item(ACT_LOAD_TGT, 16'h7FFF, 16'h8000);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(ACT_LOAD_TGT, 16'h1234, 16'hFEDC);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_COMPUTE, 0, 0);
        drain();

        // register extremes on a fixed pair of paths
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: write_regs(16'd32768, -16'sd16384, 16'd16384, 16'd2048, -16'sd2048);
                1: write_regs(16'd0, 16'd16384, -16'sd16384, -16'sd2048, 16'd2048);
                2: write_regs(16'd32768, 16'd16384, 16'd16384, 16'd2047, 16'd2047);
                default: write_regs(16'd16384, 16'd16384, 16'd0, 16'd0, 16'd0);
            endcase
            send_item(ACT_CLEAR, 0, 0);
            send_item(ACT_LOAD_SRC, 16'h7FFF, 16'h8000);
            send_item(ACT_LOAD_SRC, 16'h0800, 16'hF800);
            send_item(ACT_LOAD_TGT, 16'h8000, 16'h7FFF);
            send_item(ACT_LOAD_TGT, 16'h0100, 16'h0200);
            send_item(ACT_COMPUTE, 0, 0);
            drain();
        end

        // overflow: full source store plus one dropped point
        send_item(ACT_CLEAR, 0, 0);
        src_busy = 1;
        for (int i = 0; i < MAX_POINTS + 1; i++) send_item(ACT_LOAD_SRC, rand_coord(), rand_coord());
        src_busy = 0;
        send_item(ACT_COMPUTE, 0, 0);
        for (int i = 0; i < 3; i++) send_item(ACT_LOAD_TGT, rand_coord(), rand_coord());
        send_item(ACT_COMPUTE, 0, 0);
        src_busy = 1;
        for (int i = 0; i < MAX_POINTS; i++) send_item(ACT_LOAD_TGT, rand_coord(), rand_coord());
        src_busy = 0;
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_LOAD_TGT, 1, 1);
        send_item(ACT_LOAD_SRC, 2, 2);
        send_item(ACT_COMPUTE, 0, 0);
        drain();

        // output held off: computes back up and stall the input
        hold_left = 1000;
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_LOAD_SRC, 5, 5);
        send_item(ACT_LOAD_TGT, 9, 9);
        src_busy = 1;
        for (int i = 0; i < 5; i++) send_item(ACT_COMPUTE, 0, 0);
        src_busy = 0;
        drain();

        // random sequences
        seqs = 0;
        while (sent < 1650) begin
            if (seqs % 10 == 0) begin
                drain();
                random_regs();
            end
            seqs++;
            src_busy = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) != 0) begin
                ns = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8);
                nt = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8);
                ls = 0; lt = 0;
                send_item(ACT_CLEAR, rand_coord(), rand_coord());
                while (ls < ns || lt < nt) begin
                    if (lt >= nt || (ls < ns && $urandom_range(0, 1))) begin
                        send_item(ACT_LOAD_SRC, rand_coord(), rand_coord());
                        ls++;
                    end else begin
                        send_item(ACT_LOAD_TGT, rand_coord(), rand_coord());
                        lt++;
                    end
                end
                send_item(ACT_COMPUTE, rand_coord(), rand_coord());
                if ($urandom_range(0, 4) == 0) begin
                    send_item(ACT_LOAD_TGT, rand_coord(), rand_coord());
                    send_item(ACT_COMPUTE, rand_coord(), rand_coord());
                end
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(act_t'($urandom_range(0, 3)), rand_coord(), rand_coord());
                send_item(ACT_CLEAR, 0, 0);
            end
            src_busy = 0;
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
